>>> rtl/adfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adfd_pkg - shared types and constants of the dropout frame detector
// Frame slot control/status bundles, field widths, register indexes
// and reset values.
// ----------------------------------------------------------------------------
package adfd_pkg;

   localparam int MAX_WIN    = 1024;
   localparam int SLOT_COUNT = 3;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;   // (2^15)^2 = 2^30 needs 31 bits
   localparam int CNT_W    = 11;   // zero count, fill and window length
   localparam int HOP_W    = 10;
   localparam int ACC_W    = 41;   // exact frame energy
   localparam int ENERGY_W = 40;   // reported frame energy, saturated
   localparam int INDEX_W  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [CNT_W-1:0] WIN_FLOOR = CNT_W'(2);
   localparam logic [CNT_W-1:0] WIN_CEIL  = CNT_W'(MAX_WIN);
   localparam logic [CNT_W-1:0] CNT_SAT   = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MAX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_MIN = 2'd3;

   // register reset values
   localparam logic [CNT_W-1:0]    WIN_LEN_RST    = 11'd320;
   localparam logic [CNT_W-1:0]    ZERO_MIN_RST   = 11'd15;
   localparam logic [CNT_W-1:0]    ZERO_MAX_RST   = 11'd40;
   localparam logic [ENERGY_W-1:0] ENERGY_MIN_RST = 40'd500000000;

   // broadcast to every slot
   typedef struct packed {
      logic            adv;      // stage 2 holds an item and moves it on
      logic            flush;    // item restarts framing
      logic            is_zero;  // sample is exactly zero
      logic [SQ_W-1:0] sq;       // squared sample
   } slot_ctl_type;

   // per-slot view after this item has been added
   typedef struct packed {
      logic             act_pre;     // active after the flush, before allocation
      logic             act_upd;     // active after allocation
      logic [CNT_W-1:0] fill;
      logic [CNT_W-1:0] zero_count;
      logic [ACC_W-1:0] energy;
   } slot_stat_type;

endpackage

>>> rtl/audio_dropout_frame_detector.sv
`timescale 1ns / 1ps
// A sample is registered in stage 1, then stage 2 loads its frame result into the result register.
// Throughput: one item per cycle while rsp_stall does not hold the result register.
// Stage 1 registers the zero test and square of the sample, stage 2 updates the slots and loads the result.
// Reset (synchronous, active high) restores the register defaults, frees all slots
// and restarts frame numbering at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// audio_dropout_frame_detector - overlapping frame zero/energy detector
// Splits a sample stream into half-overlapping frames, counts exact-zero
// samples and sums squared samples per frame, and flags dropout frames.
// ----------------------------------------------------------------------------
module audio_dropout_frame_detector import adfd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,

   // configuration writes
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,

   // sample items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                    req_first,

   // frame result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [INDEX_W-1:0]      rsp_frame_index,
   output logic                    rsp_is_dropout,
   output logic [CNT_W-1:0]        rsp_zero_count,
   output logic [ENERGY_W-1:0]     rsp_energy
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]    win_len_ff;
   logic [CNT_W-1:0]    zero_min_ff;
   logic [CNT_W-1:0]    zero_max_ff;
   logic [ENERGY_W-1:0] energy_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff    <= WIN_LEN_RST;
         zero_min_ff   <= ZERO_MIN_RST;
         zero_max_ff   <= ZERO_MAX_RST;
         energy_min_ff <= ENERGY_MIN_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIN_LEN:    win_len_ff    <= csr_write_data[CNT_W-1:0];
            CSR_ZERO_MIN:   zero_min_ff   <= csr_write_data[CNT_W-1:0];
            CSR_ZERO_MAX:   zero_max_ff   <= csr_write_data[CNT_W-1:0];
            CSR_ENERGY_MIN: energy_min_ff <= csr_write_data[ENERGY_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the window so the hop never reaches zero
   logic [CNT_W-1:0] win;
   logic [HOP_W-1:0] hop;

   always_comb begin
      if (win_len_ff < WIN_FLOOR) begin
         win = WIN_FLOOR;
      end else if (win_len_ff > WIN_CEIL) begin
         win = WIN_CEIL;
      end else begin
         win = win_len_ff;
      end
      hop = win[CNT_W-1:1];
   end

   // ---------------------------------------------------------------------
   // handshake: stage 2 advances when it holds an item and the result register is free
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_free, adv, s1_load;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign adv       = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !adv;
   assign s1_load   = req_valid && !req_stall;
   assign s1_valid_in = s1_load || (s1_valid_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: register the sample's first flag, its zero test and its square
   // ---------------------------------------------------------------------
   logic              first_ff;
   logic              is_zero_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic signed [2*SAMPLE_W-1:0] sq_full;

   assign sq_full = req_sample * req_sample;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         first_ff   <= req_first;
         is_zero_ff <= (req_sample == '0);
         sq_ff      <= sq_full[SQ_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: frame slots
   // ---------------------------------------------------------------------
   slot_ctl_type           slot_ctl;
   slot_stat_type          stat [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  alloc_vec;
   logic [SLOT_COUNT-1:0]  retire_vec;

   assign slot_ctl.adv     = adv;
   assign slot_ctl.flush   = first_ff;
   assign slot_ctl.is_zero = is_zero_ff;
   assign slot_ctl.sq      = sq_ff;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
      adfd_slot u_slot (
         .clock  (clock),
         .reset  (reset),
         .ctl    (slot_ctl),
         .alloc  (alloc_vec[g]),
         .retire (retire_vec[g]),
         .stat   (stat[g])
      );
   end

   logic [HOP_W-1:0]      hop_ff, hop_in;
   logic [HOP_W-1:0]      hop_cur, hop_step;
   logic [INDEX_W-1:0]    done_idx_ff, done_idx_in;
   logic                  found;
   logic                  done_any;
   logic [SLOT_IDX_W-1:0] done_sel;
   logic [CNT_W-1:0]      done_fill;

   always_comb begin
      // a first sample restarts the hop count with this sample
      hop_cur   = first_ff ? '0 : hop_ff;
      alloc_vec = '0;
      found     = 1'b0;
      // open a new frame at each hop boundary in the lowest free slot
      if (hop_cur == '0) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && !stat[i].act_pre) begin
               alloc_vec[i] = 1'b1;
               found        = 1'b1;
            end
         end
      end

      hop_step = hop_cur + HOP_W'(1);
      hop_in   = (hop_step >= hop) ? '0 : hop_step;

      // report the fullest finished frame; ties go to the lower slot
      done_any  = 1'b0;
      done_sel  = '0;
      done_fill = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (stat[i].act_upd && (stat[i].fill >= win)) begin
            if (!done_any || (stat[i].fill > done_fill)) begin
               done_any  = 1'b1;
               done_sel  = SLOT_IDX_W'(i);
               done_fill = stat[i].fill;
            end
         end
      end

      retire_vec = '0;
      if (done_any) begin
         retire_vec[done_sel] = 1'b1;
      end

      done_idx_in = first_ff ? '0 : done_idx_ff;
      if (done_any) begin
         done_idx_in = done_idx_in + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff      <= '0;
         done_idx_ff <= '0;
      end else if (adv) begin
         hop_ff      <= hop_in;
         done_idx_ff <= done_idx_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  frame_index_ff;
   logic                is_dropout_ff;
   logic [CNT_W-1:0]    zero_count_ff;
   logic [ENERGY_W-1:0] energy_ff;

   logic [CNT_W-1:0]    sel_zc;
   logic [ACC_W-1:0]    sel_en;
   logic                sel_flag;

   always_comb begin
      sel_zc   = stat[done_sel].zero_count;
      sel_en   = stat[done_sel].energy;
      // the flag uses the exact energy, the reported value saturates
      sel_flag = (sel_zc > zero_min_ff) && (sel_zc < zero_max_ff)
                 && (sel_en > ACC_W'(energy_min_ff));
      rsp_valid_in = out_free ? (adv && done_any) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && done_any) begin
         frame_index_ff <= first_ff ? '0 : done_idx_ff;
         is_dropout_ff  <= sel_flag;
         zero_count_ff  <= sel_zc;
         energy_ff      <= sel_en[ACC_W-1] ? '1 : sel_en[ENERGY_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = frame_index_ff;
   assign rsp_is_dropout  = is_dropout_ff;
   assign rsp_zero_count  = zero_count_ff;
   assign rsp_energy      = energy_ff;

endmodule

>>> rtl/adfd_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adfd_slot - one frame accumulator
// Counts zero samples, sums squares exactly and tracks fill of one frame.
// ----------------------------------------------------------------------------
module adfd_slot import adfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  slot_ctl_type  ctl,
   input  logic          alloc,
   input  logic          retire,
   output slot_stat_type stat
);

   logic             active_ff, active_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] zc_ff, zc_in;
   logic [ACC_W-1:0] en_ff, en_in;

   logic             act_pre, act_mid;
   logic [CNT_W-1:0] fill_base, zc_base;
   logic [ACC_W-1:0] en_base;

   always_comb begin
      act_pre   = active_ff & ~ctl.flush;
      act_mid   = act_pre | alloc;
      fill_base = alloc ? '0 : fill_ff;
      zc_base   = alloc ? '0 : zc_ff;
      en_base   = alloc ? '0 : en_ff;

      fill_in = fill_base;
      zc_in   = zc_base;
      en_in   = en_base;
      if (act_mid) begin
         if (fill_base != CNT_SAT) begin
            fill_in = fill_base + CNT_W'(1);
         end
         if (ctl.is_zero && (zc_base != CNT_SAT)) begin
            zc_in = zc_base + CNT_W'(1);
         end
         en_in = en_base + ACC_W'(ctl.sq);
      end
      // drop the slot once its frame has been reported
      active_in = act_mid & ~retire;

      stat.act_pre    = act_pre;
      stat.act_upd    = act_mid;
      stat.fill       = fill_in;
      stat.zero_count = zc_in;
      stat.energy     = en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (ctl.adv) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         fill_ff <= fill_in;
         zc_ff   <= zc_in;
         en_ff   <= en_in;
      end
   end

endmodule
